// File: rtl/dfd_pkg.sv
`default_nettype none

package dfd_pkg;

  localparam int SAMPLE_WIDTH = 32;
  localparam int STEP_WIDTH   = 16;
  localparam int D1_WIDTH     = SAMPLE_WIDTH + 1;
  localparam int D2_WIDTH     = SAMPLE_WIDTH + 2;
  localparam int D3_WIDTH     = SAMPLE_WIDTH + 3;
  localparam int KEPT_WIDTH   = 2;
  localparam int DIV_COUNT_WIDTH = $clog2(D1_WIDTH + 1);

  localparam logic [KEPT_WIDTH-1:0] KEPT_NONE = KEPT_WIDTH'(0);
  localparam logic [KEPT_WIDTH-1:0] KEPT_ONE  = KEPT_WIDTH'(1);
  localparam logic [KEPT_WIDTH-1:0] KEPT_MAX  = KEPT_WIDTH'(3);

  localparam logic [STEP_WIDTH-1:0] STEP_RESET = STEP_WIDTH'(1);

  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_DIVIDE = 3'b010,
    S_COMMIT = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic div_start;
    logic commit;
    logic cfg_write;
  } dfd_cmd_t;

  typedef struct packed {
    logic need_div;
    logic div_done;
    logic out_free;
  } dfd_status_t;

endpackage

`default_nettype wire

// File: rtl/dfd_div.sv
`default_nettype none

module dfd_div (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic signed [dfd_pkg::D1_WIDTH-1:0] num,
  input  wire logic [dfd_pkg::STEP_WIDTH-1:0]    den,
  output logic                                   done,
  output logic signed [dfd_pkg::D1_WIDTH-1:0]    quot
);

  localparam int NW = dfd_pkg::D1_WIDTH;
  localparam int SW = dfd_pkg::STEP_WIDTH;
  localparam int CW = dfd_pkg::DIV_COUNT_WIDTH;

  logic          busy;
  logic [CW-1:0] count;
  logic [SW-1:0] rem;
  logic [NW-1:0] quo;
  logic [SW-1:0] divisor;
  logic          negative;

  logic [SW:0]   trial;
  logic [SW:0]   trial_sub;
  logic          fits;
  logic [NW-1:0] magnitude;

  assign magnitude = num[NW-1] ? (~num + NW'(1)) : num;
  assign trial     = {rem, quo[NW-1]};
  assign fits      = trial >= {1'b0, divisor};
  assign trial_sub = trial - {1'b0, divisor};
  assign quot      = $signed(negative ? (~quo + NW'(1)) : quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        count <= '0;
      end else if (busy) begin
        count <= count + CW'(1);
        if (count == CW'(NW - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= magnitude;
      divisor <= den;
      negative <= num[NW-1];
    end else if (busy) begin
      rem <= fits ? trial_sub[SW-1:0] : trial[SW-1:0];
      quo <= {quo[NW-2:0], fits};
    end
  end

  assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("Divider started while an item is still being divided.");

endmodule

`default_nettype wire

// File: rtl/dfd_dp.sv
`default_nettype none

module dfd_dp (
  input  wire logic                                 clk,
  input  wire logic                                 rst,
  input  wire dfd_pkg::dfd_cmd_t                    cmd,
  output dfd_pkg::dfd_status_t                      status,
  input  wire logic signed [dfd_pkg::SAMPLE_WIDTH-1:0] sample_value,
  input  wire logic [dfd_pkg::STEP_WIDTH-1:0]       cfg_data,
  input  wire logic                                 out_stall,
  output logic                                      out_valid,
  output logic signed [dfd_pkg::D1_WIDTH-1:0]       first_deriv,
  output logic signed [dfd_pkg::D2_WIDTH-1:0]       second_deriv,
  output logic signed [dfd_pkg::D3_WIDTH-1:0]       third_deriv,
  output logic                                      first_valid,
  output logic                                      second_valid,
  output logic                                      third_valid
);

  localparam int XW = dfd_pkg::SAMPLE_WIDTH;
  localparam int SW = dfd_pkg::STEP_WIDTH;
  localparam int W1 = dfd_pkg::D1_WIDTH;
  localparam int W2 = dfd_pkg::D2_WIDTH;
  localparam int W3 = dfd_pkg::D3_WIDTH;
  localparam int KW = dfd_pkg::KEPT_WIDTH;

  logic [SW-1:0]        step;
  logic [SW-1:0]        phase;
  logic [KW-1:0]        kept;
  logic                 keep_item;
  logic signed [XW-1:0] sample_hold;
  logic signed [XW-1:0] last_kept_sample;
  logic signed [W1-1:0] newer_first;
  logic signed [W2-1:0] newer_second;

  logic signed [W1-1:0] div_num;
  logic signed [W1-1:0] div_quot;
  logic                 div_done;

  logic [SW-1:0]        phase_inc;
  logic [SW-1:0]        phase_next;
  logic [KW-1:0]        kept_next;
  logic signed [W2-1:0] second_new;
  logic signed [W3-1:0] third_new;
  logic                 has_first;
  logic                 has_second;
  logic                 has_third;

  assign div_num = W1'(sample_value) - W1'(last_kept_sample);

  dfd_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (div_num),
    .den   (step),
    .done  (div_done),
    .quot  (div_quot)
  );

  assign phase_inc  = phase + SW'(1);
  assign phase_next = (phase_inc >= step) ? '0 : phase_inc;
  assign kept_next  = (kept == dfd_pkg::KEPT_MAX) ? kept : kept + KW'(1);

  assign has_first  = keep_item && (kept != dfd_pkg::KEPT_NONE);
  assign has_second = keep_item && (kept != dfd_pkg::KEPT_NONE) && (kept != dfd_pkg::KEPT_ONE);
  assign has_third  = keep_item && (kept == dfd_pkg::KEPT_MAX);

  assign second_new = W2'(div_quot) - W2'(newer_first);
  assign third_new  = W3'(second_new) - W3'(newer_second);

  assign status.need_div = (phase == '0) && (kept != dfd_pkg::KEPT_NONE);
  assign status.div_done = div_done;
  assign status.out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= dfd_pkg::STEP_RESET;
      phase <= '0;
      kept <= dfd_pkg::KEPT_NONE;
      out_valid <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (cmd.cfg_write) begin
        if (cfg_data != '0) begin
          step <= cfg_data;
        end
        phase <= '0;
        kept <= dfd_pkg::KEPT_NONE;
      end else if (cmd.commit) begin
        phase <= phase_next;
        if (keep_item) begin
          kept <= kept_next;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      sample_hold <= sample_value;
      keep_item <= (phase == '0);
    end
    if (cmd.commit) begin
      if (keep_item) begin
        last_kept_sample <= sample_hold;
      end
      if (has_first) begin
        newer_first <= div_quot;
      end
      if (has_second) begin
        newer_second <= second_new;
      end
      first_deriv  <= has_first ? div_quot : '0;
      second_deriv <= has_second ? second_new : '0;
      third_deriv  <= has_third ? third_new : '0;
      first_valid  <= has_first;
      second_valid <= has_second;
      third_valid  <= has_third;
    end
  end

  assert property (@(posedge clk) disable iff (rst) phase < step)
    else $error("Decimation phase has reached the step.");

  assert property (@(posedge clk) disable iff (rst)
    !cmd.cfg_write |=> kept >= $past(kept))
    else $error("Kept sample count fell without a restart.");

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (!third_valid || second_valid) && (!second_valid || first_valid))
    else $error("A higher derivative is flagged without the lower ones.");

endmodule

`default_nettype wire

// File: rtl/dfd_ctrl.sv
`default_nettype none

module dfd_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire dfd_pkg::dfd_status_t status,
  output dfd_pkg::dfd_cmd_t         cmd
);

  dfd_pkg::state_t state;
  dfd_pkg::state_t state_next;
  logic            idle;

  assign idle      = (state == dfd_pkg::S_IDLE);
  assign cfg_ready = idle;
  assign in_stall  = !idle || cfg_valid;

  assign cmd.cfg_write = idle && cfg_valid;
  assign cmd.capture   = idle && in_valid && !cfg_valid;
  assign cmd.div_start = cmd.capture && status.need_div;
  assign cmd.commit    = (state == dfd_pkg::S_COMMIT) && status.out_free;

  always_comb begin
    state_next = state;
    case (state)
      dfd_pkg::S_IDLE: begin
        if (cmd.capture) begin
          state_next = status.need_div ? dfd_pkg::S_DIVIDE : dfd_pkg::S_COMMIT;
        end
      end
      dfd_pkg::S_DIVIDE: begin
        if (status.div_done) begin
          state_next = dfd_pkg::S_COMMIT;
        end
      end
      dfd_pkg::S_COMMIT: begin
        if (status.out_free) begin
          state_next = dfd_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = dfd_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dfd_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

// File: rtl/decimated_finite_difference_engine.sv
// Channel   Handshake              Payload
// input     in_valid / in_stall    sample_value
// output    out_valid / out_stall  first_deriv, second_deriv, third_deriv, *_valid
// config    cfg_valid / cfg_ready  step_size
//
// An item that is not kept, or is the first kept sample, goes from capture straight to its commit.
// A kept item that needs the first difference also waits in the divide state
// for the one-bit-per-cycle restoring divider that divides by the step.
// Reset is synchronous and active high; it sets the step to one and restarts.
// A stalled result waits in the output register; the next item is taken
// meanwhile and held at its commit until the register is free.
`default_nettype none

module decimated_finite_difference_engine (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic signed [dfd_pkg::SAMPLE_WIDTH-1:0] sample_value,
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic signed [dfd_pkg::D1_WIDTH-1:0]        first_deriv,
  output logic signed [dfd_pkg::D2_WIDTH-1:0]        second_deriv,
  output logic signed [dfd_pkg::D3_WIDTH-1:0]        third_deriv,
  output logic                                       first_valid,
  output logic                                       second_valid,
  output logic                                       third_valid,
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [dfd_pkg::STEP_WIDTH-1:0]        step_size
);

  dfd_pkg::dfd_cmd_t    cmd;
  dfd_pkg::dfd_status_t status;

  dfd_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .status    (status),
    .cmd       (cmd)
  );

  dfd_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .status       (status),
    .sample_value (sample_value),
    .cfg_data     (step_size),
    .out_stall    (out_stall),
    .out_valid    (out_valid),
    .first_deriv  (first_deriv),
    .second_deriv (second_deriv),
    .third_deriv  (third_deriv),
    .first_valid  (first_valid),
    .second_valid (second_valid),
    .third_valid  (third_valid)
  );

endmodule

`default_nettype wire
